/* sv/cmcp_pkg.sv */
// Shared types, constants and arithmetic helpers for the complex matrix chain product core.
package cmcp_pkg;

    localparam int DATA_W  = 32;
    localparam int CHAIN_W = 10;

    localparam logic signed [35:0] SAT_MAX = 36'sd2147483647;
    localparam logic signed [35:0] SAT_MIN = -36'sd2147483648;
    localparam logic signed [63:0] RND_HALF = 64'sd536870912;

    typedef struct packed {
        logic in_load;
        logic acc_wr;
        logic mac_issue;
        logic swap;
        logic clear_part;
    } t_dp_cmd;

    typedef struct packed {
        logic busy;
    } t_dp_status;

    // Q2.60 product to Q1.30, round half up (floor after adding half an lsb)
    function automatic logic signed [33:0] round_q30(input logic signed [63:0] p);
        logic signed [63:0] x;
        x = p + RND_HALF;
        return x[63:30];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] res;
        if (v > SAT_MAX) begin
            res = 32'sh7FFFFFFF;
        end else if (v < SAT_MIN) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

/* sv/cmcp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module cmcp_ram #(
    parameter int W     = 64,
    parameter int DEPTH = 9
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [W-1:0]             i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [W-1:0]             o_rd_data
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* sv/cmcp_datapath.sv */
// Datapath: ping-pong accumulator/partial banks and the pipelined complex MAC.
module cmcp_datapath import cmcp_pkg::*; #(
    parameter int MATRIX_DIM = 3
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  t_dp_cmd                                     i_cmd,
    output t_dp_status                                  o_status,
    input  logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0]    i_acc_addr,
    input  logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0]    i_part_addr,
    input  logic signed [DATA_W-1:0]                    i_elem_re,
    input  logic signed [DATA_W-1:0]                    i_elem_im,
    output logic signed [DATA_W-1:0]                    o_acc_re,
    output logic signed [DATA_W-1:0]                    o_acc_im
);

    localparam int NSQ = MATRIX_DIM * MATRIX_DIM;
    localparam int AW  = $clog2(NSQ);

    logic                      r_acc_sel;
    logic [NSQ-1:0]            r_pvalid;

    logic signed [DATA_W-1:0]  r_br;
    logic signed [DATA_W-1:0]  r_bi;

    logic                      r_b_vld;
    logic [AW-1:0]             r_b_addr;
    logic                      r_b_pv;

    logic                      r_c_vld;
    logic [AW-1:0]             r_c_addr;
    logic signed [63:0]        r_c_rr;
    logic signed [63:0]        r_c_ii;
    logic signed [63:0]        r_c_ri;
    logic signed [63:0]        r_c_ir;
    logic signed [DATA_W-1:0]  r_c_part_re;
    logic signed [DATA_W-1:0]  r_c_part_im;

    logic                      r_d_vld;
    logic [AW-1:0]             r_d_addr;
    logic signed [34:0]        r_d_tr;
    logic signed [34:0]        r_d_ti;
    logic signed [DATA_W-1:0]  r_d_part_re;
    logic signed [DATA_W-1:0]  r_d_part_im;

    logic [63:0]               w_rd0;
    logic [63:0]               w_rd1;
    logic [63:0]               w_acc_rd;
    logic [63:0]               w_part_rd;
    logic                      w_we0;
    logic                      w_we1;
    logic [AW-1:0]             w_wa0;
    logic [AW-1:0]             w_wa1;
    logic [63:0]               w_wd0;
    logic [63:0]               w_wd1;
    logic [AW-1:0]             w_ra0;
    logic [AW-1:0]             w_ra1;

    logic signed [DATA_W-1:0]  w_ar;
    logic signed [DATA_W-1:0]  w_ai;
    logic signed [33:0]        w_rr;
    logic signed [33:0]        w_ii;
    logic signed [33:0]        w_ri;
    logic signed [33:0]        w_ir;
    logic signed [35:0]        w_sum_re;
    logic signed [35:0]        w_sum_im;
    logic signed [DATA_W-1:0]  w_new_re;
    logic signed [DATA_W-1:0]  w_new_im;
    logic [63:0]               w_acc_wd;
    logic [63:0]               w_part_wd;

    // bank select: r_acc_sel == 0 means ram0 holds the accumulator
    assign w_acc_rd  = r_acc_sel ? w_rd1 : w_rd0;
    assign w_part_rd = r_acc_sel ? w_rd0 : w_rd1;
    assign w_acc_wd  = {i_elem_im, i_elem_re};
    assign w_part_wd = {w_new_im, w_new_re};

    always_comb begin
        w_we0 = r_acc_sel ? r_d_vld  : i_cmd.acc_wr;
        w_wa0 = r_acc_sel ? r_d_addr : i_acc_addr;
        w_wd0 = r_acc_sel ? w_part_wd : w_acc_wd;
        w_ra0 = r_acc_sel ? i_part_addr : i_acc_addr;
        w_we1 = r_acc_sel ? i_cmd.acc_wr : r_d_vld;
        w_wa1 = r_acc_sel ? i_acc_addr : r_d_addr;
        w_wd1 = r_acc_sel ? w_acc_wd : w_part_wd;
        w_ra1 = r_acc_sel ? i_acc_addr : i_part_addr;
    end

    cmcp_ram #(.W(64), .DEPTH(NSQ)) u_ram0 (
        .i_clk     (i_clk),
        .i_wr_en   (w_we0),
        .i_wr_addr (w_wa0),
        .i_wr_data (w_wd0),
        .i_rd_addr (w_ra0),
        .o_rd_data (w_rd0)
    );

    cmcp_ram #(.W(64), .DEPTH(NSQ)) u_ram1 (
        .i_clk     (i_clk),
        .i_wr_en   (w_we1),
        .i_wr_addr (w_wa1),
        .i_wr_data (w_wd1),
        .i_rd_addr (w_ra1),
        .o_rd_data (w_rd1)
    );

    assign w_ar = w_acc_rd[31:0];
    assign w_ai = w_acc_rd[63:32];

    assign w_rr = round_q30(r_c_rr);
    assign w_ii = round_q30(r_c_ii);
    assign w_ri = round_q30(r_c_ri);
    assign w_ir = round_q30(r_c_ir);

    assign w_sum_re = 36'(r_d_part_re) + 36'(r_d_tr);
    assign w_sum_im = 36'(r_d_part_im) + 36'(r_d_ti);
    assign w_new_re = sat32(w_sum_re);
    assign w_new_im = sat32(w_sum_im);

    assign o_acc_re = w_acc_rd[31:0];
    assign o_acc_im = w_acc_rd[63:32];
    assign o_status.busy = r_b_vld | r_c_vld | r_d_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_sel <= 1'b0;
            r_pvalid  <= '0;
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_d_vld   <= 1'b0;
        end else begin
            if (i_cmd.swap) begin
                r_acc_sel <= ~r_acc_sel;
            end
            if (i_cmd.clear_part) begin
                r_pvalid <= '0;
            end else if (r_d_vld) begin
                r_pvalid[r_d_addr] <= 1'b1;
            end
            r_b_vld <= i_cmd.mac_issue;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_br <= i_elem_re;
            r_bi <= i_elem_im;
        end
        r_b_addr    <= i_part_addr;
        r_b_pv      <= r_pvalid[i_part_addr];

        r_c_addr    <= r_b_addr;
        r_c_rr      <= w_ar * r_br;
        r_c_ii      <= w_ai * r_bi;
        r_c_ri      <= w_ar * r_bi;
        r_c_ir      <= w_ai * r_br;
        r_c_part_re <= r_b_pv ? w_part_rd[31:0]  : '0;
        r_c_part_im <= r_b_pv ? w_part_rd[63:32] : '0;

        r_d_addr    <= r_c_addr;
        r_d_tr      <= 35'(w_rr) - 35'(w_ii);
        r_d_ti      <= 35'(w_ri) + 35'(w_ir);
        r_d_part_re <= r_c_part_re;
        r_d_part_im <= r_c_part_im;
    end

endmodule

/* sv/cmcp_ctrl.sv */
// Controller: element/link sequencing, MAC issue, link-end bank swap and product readout.
module cmcp_ctrl import cmcp_pkg::*; #(
    parameter int MATRIX_DIM = 3
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_in_valid,
    output logic                                        o_in_ready,
    output logic                                        o_out_valid,
    input  logic                                        i_out_ready,
    output logic                                        o_last_elem,
    input  logic                                        i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  logic [CHAIN_W-1:0]                          i_cfg_data,
    input  t_dp_status                                  i_status,
    output t_dp_cmd                                     o_cmd,
    output logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0]    o_acc_addr,
    output logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0]    o_part_addr
);

    localparam int NSQ = MATRIX_DIM * MATRIX_DIM;
    localparam int AW  = $clog2(NSQ);
    localparam int IW  = $clog2(MATRIX_DIM);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_MAC    = 5'b00010,
        S_DRAIN  = 5'b00100,
        S_EM_RD  = 5'b01000,
        S_EM_OUT = 5'b10000
    } t_state;

    t_state              r_state,     n_state;
    logic [AW-1:0]       r_elem,      n_elem;
    logic [IW-1:0]       r_row,       n_row;
    logic [IW-1:0]       r_col,       n_col;
    logic [IW-1:0]       r_iter,      n_iter;
    logic [AW-1:0]       r_acc_addr,  n_acc_addr;
    logic [AW-1:0]       r_part_addr, n_part_addr;
    logic [AW-1:0]       r_emit,      n_emit;
    logic [CHAIN_W-1:0]  r_link,      n_link;
    logic [CHAIN_W-1:0]  r_chain_len;

    logic [CHAIN_W-1:0]  w_link_inc;
    logic [CHAIN_W-1:0]  w_eff_len;
    logic                w_chain_done;
    logic                w_last_elem;

    assign w_link_inc   = r_link + 1'b1;
    assign w_eff_len    = (r_chain_len == '0) ? CHAIN_W'(1) : r_chain_len;
    assign w_chain_done = (w_link_inc >= w_eff_len) || (w_link_inc == '0);
    assign w_last_elem  = (r_elem == AW'(NSQ - 1));

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EM_OUT);
    assign o_last_elem = (r_emit == AW'(NSQ - 1));
    assign o_cfg_ready = 1'b1;
    assign o_part_addr = r_part_addr;

    always_comb begin
        case (r_state)
            S_IDLE:  o_acc_addr = r_elem;
            S_MAC:   o_acc_addr = r_acc_addr;
            default: o_acc_addr = r_emit;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_elem      = r_elem;
        n_row       = r_row;
        n_col       = r_col;
        n_iter      = r_iter;
        n_acc_addr  = r_acc_addr;
        n_part_addr = r_part_addr;
        n_emit      = r_emit;
        n_link      = r_link;
        o_cmd       = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.in_load = 1'b1;
                    if (r_link == '0) begin
                        o_cmd.acc_wr = 1'b1;
                        if (w_last_elem) begin
                            n_elem = '0;
                            n_row  = '0;
                            n_col  = '0;
                            o_cmd.clear_part = 1'b1;
                            if (w_chain_done) begin
                                n_link  = '0;
                                n_state = S_EM_RD;
                            end else begin
                                n_link = w_link_inc;
                            end
                        end else begin
                            n_elem = r_elem + 1'b1;
                            if (r_col == IW'(MATRIX_DIM - 1)) begin
                                n_col = '0;
                                n_row = r_row + 1'b1;
                            end else begin
                                n_col = r_col + 1'b1;
                            end
                        end
                    end else begin
                        n_iter      = '0;
                        n_acc_addr  = AW'(r_row);
                        n_part_addr = AW'(r_col);
                        n_state     = S_MAC;
                    end
                end
            end
            S_MAC: begin
                o_cmd.mac_issue = 1'b1;
                n_iter      = r_iter + 1'b1;
                n_acc_addr  = r_acc_addr + AW'(MATRIX_DIM);
                n_part_addr = r_part_addr + AW'(MATRIX_DIM);
                if (r_iter == IW'(MATRIX_DIM - 1)) begin
                    if (w_last_elem) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_state = S_IDLE;
                        n_elem  = r_elem + 1'b1;
                        if (r_col == IW'(MATRIX_DIM - 1)) begin
                            n_col = '0;
                            n_row = r_row + 1'b1;
                        end else begin
                            n_col = r_col + 1'b1;
                        end
                    end
                end
            end
            S_DRAIN: begin
                if (!i_status.busy) begin
                    o_cmd.swap       = 1'b1;
                    o_cmd.clear_part = 1'b1;
                    n_elem = '0;
                    n_row  = '0;
                    n_col  = '0;
                    if (w_chain_done) begin
                        n_link  = '0;
                        n_state = S_EM_RD;
                    end else begin
                        n_link  = w_link_inc;
                        n_state = S_IDLE;
                    end
                end
            end
            S_EM_RD: begin
                n_state = S_EM_OUT;
            end
            S_EM_OUT: begin
                if (i_out_ready) begin
                    if (r_emit == AW'(NSQ - 1)) begin
                        n_emit  = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_emit  = r_emit + 1'b1;
                        n_state = S_EM_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_elem      <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_iter      <= '0;
            r_acc_addr  <= '0;
            r_part_addr <= '0;
            r_emit      <= '0;
            r_link      <= '0;
            r_chain_len <= CHAIN_W'(1);
        end else begin
            r_state     <= n_state;
            r_elem      <= n_elem;
            r_row       <= n_row;
            r_col       <= n_col;
            r_iter      <= n_iter;
            r_acc_addr  <= n_acc_addr;
            r_part_addr <= n_part_addr;
            r_emit      <= n_emit;
            r_link      <= n_link;
            if (i_cfg_valid) begin
                r_chain_len <= i_cfg_data;
            end
        end
    end

endmodule

/* sv/complex_matrix_chain_product_core.sv */
// Top level of the complex matrix chain product core: controller, datapath and checks.
// A first-link element is written straight into the accumulator bank; a later-link
//   element waits on the single shared complex MAC (one term a cycle) with input blocked.
// The last element of a later link lets the MAC pipeline drain before the bank swap.
// Readout: MATRIX_DIM*MATRIX_DIM elements; read state, then output state held until ready.
// Reset: synchronous active low; clears control state, chain_length returns to 1.
module complex_matrix_chain_product_core import cmcp_pkg::*; #(
    parameter int MATRIX_DIM = 3
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic signed [DATA_W-1:0]  i_elem_re,
    input  logic signed [DATA_W-1:0]  i_elem_im,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [DATA_W-1:0]  o_prod_re,
    output logic signed [DATA_W-1:0]  o_prod_im,
    output logic                      o_last_elem,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CHAIN_W-1:0]        i_cfg_chain_length
);

    localparam int AW = $clog2(MATRIX_DIM * MATRIX_DIM);

    t_dp_cmd     w_cmd;
    t_dp_status  w_status;
    logic [AW-1:0] w_acc_addr;
    logic [AW-1:0] w_part_addr;

    cmcp_ctrl #(.MATRIX_DIM(MATRIX_DIM)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_last_elem (o_last_elem),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_chain_length),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_acc_addr  (w_acc_addr),
        .o_part_addr (w_part_addr)
    );

    cmcp_datapath #(.MATRIX_DIM(MATRIX_DIM)) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_acc_addr  (w_acc_addr),
        .i_part_addr (w_part_addr),
        .i_elem_re   (i_elem_re),
        .i_elem_im   (i_elem_im),
        .o_acc_re    (o_prod_re),
        .o_acc_im    (o_prod_im)
    );

    // no request taken while the product is being read out
    a_no_in_during_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input accepted during product readout");

    // banks swap only once the MAC pipeline has drained
    a_swap_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.swap |-> !w_status.busy)
        else $error("bank swap with MAC writes in flight");

    // first-link loads never overlap partial writebacks
    a_load_idle_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.acc_wr |-> !w_status.busy)
        else $error("accumulator load while MAC pipeline busy");

    // readout ends after the flagged element
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last_elem) |=> !o_out_valid)
        else $error("output continues past last element");

endmodule

/* tb/tb.sv */
// Self-checking testbench for complex_matrix_chain_product_core: random chains against a predictor.
module tb import cmcp_pkg::*; ();

    localparam int MATRIX_DIM   = 3;
    localparam int NSQ          = MATRIX_DIM * MATRIX_DIM;
    localparam int DRAIN_CYCLES = 40;
    localparam int RAND_ITEMS   = 260;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFFFFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh80000000;
    localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh40000000;

    typedef struct {
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
    } t_link_elem;

    typedef struct {
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
        logic                     last;
    } t_prod_elem;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic signed [DATA_W-1:0]  i_elem_re = '0;
    logic signed [DATA_W-1:0]  i_elem_im = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic signed [DATA_W-1:0]  o_prod_re;
    logic signed [DATA_W-1:0]  o_prod_im;
    logic                      o_last_elem;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CHAIN_W-1:0]        i_cfg_chain_length = '0;

    t_link_elem  pending_elems[$];
    t_prod_elem  expected_prods[$];
    int          n_queued = 0;
    int          n_accepted = 0;
    int          fail_count = 0;
    int unsigned tx_idle_pct = 10;
    int unsigned rx_idle_pct = 83;

    // chain product state
    logic signed [63:0] acc_re [NSQ];
    logic signed [63:0] acc_im [NSQ];
    logic signed [63:0] part_re [NSQ];
    logic signed [63:0] part_im [NSQ];
    int unsigned        elem_idx = 0;
    int unsigned        links_done = 0;
    logic [CHAIN_W-1:0] chain_len = CHAIN_W'(1);

    complex_matrix_chain_product_core #(
        .MATRIX_DIM(MATRIX_DIM)
    ) i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_elem_re          (i_elem_re),
        .i_elem_im          (i_elem_im),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_prod_re          (o_prod_re),
        .o_prod_im          (o_prod_im),
        .o_last_elem        (o_last_elem),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_chain_length (i_cfg_chain_length)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic signed [63:0] q30_round(input logic signed [63:0] p);
        return (p + 64'sd536870912) >>> 30;
    endfunction

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
        logic signed [63:0] res;
        if (v > 64'sd2147483647) begin
            res = 64'sd2147483647;
        end else if (v < -64'sd2147483648) begin
            res = -64'sd2147483648;
        end else begin
            res = v;
        end
        return res;
    endfunction

    task automatic predict_link_elem(input logic signed [DATA_W-1:0] b_re,
                                     input logic signed [DATA_W-1:0] b_im);
        logic signed [63:0] br, bi, ar, ai, tr, ti;
        int unsigned        r, c, d, eff;
        t_prod_elem         p;
        br  = b_re;
        bi  = b_im;
        r   = elem_idx / MATRIX_DIM;
        c   = elem_idx % MATRIX_DIM;
        eff = (chain_len == 0) ? 1 : chain_len;
        if (links_done == 0) begin
            acc_re[elem_idx] = br;
            acc_im[elem_idx] = bi;
        end else begin
            for (int i = 0; i < MATRIX_DIM; i++) begin
                ar = acc_re[i * MATRIX_DIM + r];
                ai = acc_im[i * MATRIX_DIM + r];
                tr = q30_round(ar * br) - q30_round(ai * bi);
                ti = q30_round(ar * bi) + q30_round(ai * br);
                d  = i * MATRIX_DIM + c;
                part_re[d] = clamp32(part_re[d] + tr);
                part_im[d] = clamp32(part_im[d] + ti);
            end
        end
        if (elem_idx + 1 < NSQ) begin
            elem_idx++;
        end else begin
            elem_idx = 0;
            for (int i = 0; i < NSQ; i++) begin
                if (links_done != 0) begin
                    acc_re[i] = part_re[i];
                    acc_im[i] = part_im[i];
                end
                part_re[i] = '0;
                part_im[i] = '0;
            end
            links_done = (links_done + 1) % 1024;
            if (links_done >= eff || links_done == 0) begin
                for (int i = 0; i < NSQ; i++) begin
                    p.re   = acc_re[i][DATA_W-1:0];
                    p.im   = acc_im[i][DATA_W-1:0];
                    p.last = (i == NSQ - 1);
                    expected_prods.push_back(p);
                end
                links_done = 0;
            end
        end
    endtask

    // input driver: one request per accepted element
    always @(posedge i_clk) begin : elem_driver
        t_link_elem nxt;
        logic       holding;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            holding = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                predict_link_elem(i_elem_re, i_elem_im);
                n_accepted++;
                holding = 1'b0;
            end
            if (!holding) begin
                if (pending_elems.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                    nxt = pending_elems.pop_front();
                    i_in_valid <= 1'b1;
                    i_elem_re  <= nxt.re;
                    i_elem_im  <= nxt.im;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : prod_monitor
        t_prod_elem want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_prods.size() == 0) begin
                    $error("unexpected product element re=%0d im=%0d last=%0b",
                           o_prod_re, o_prod_im, o_last_elem);
                    fail_count++;
                end else begin
                    want = expected_prods.pop_front();
                    if (o_prod_re !== want.re) begin
                        $error("prod_re mismatch: expected %0d, actual %0d", want.re, o_prod_re);
                        fail_count++;
                    end
                    if (o_prod_im !== want.im) begin
                        $error("prod_im mismatch: expected %0d, actual %0d", want.im, o_prod_im);
                        fail_count++;
                    end
                    if (o_last_elem !== want.last) begin
                        $error("last_elem mismatch: expected %0b, actual %0b",
                               want.last, o_last_elem);
                        fail_count++;
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic logic signed [DATA_W-1:0] rand_q30();
        logic signed [DATA_W-1:0] raw;
        logic signed [DATA_W-1:0] v;
        raw = $urandom;
        case ($urandom_range(9))
            0:       v = Q_MIN;
            1:       v = Q_MAX;
            2, 3:    v = raw;
            default: v = raw >>> $urandom_range(1, 5);
        endcase
        return v;
    endfunction

    task automatic push_elem(input logic signed [DATA_W-1:0] re,
                             input logic signed [DATA_W-1:0] im);
        t_link_elem e;
        e.re = re;
        e.im = im;
        pending_elems.push_back(e);
        n_queued++;
    endtask

    task automatic push_rand_link();
        for (int k = 0; k < NSQ; k++) begin
            push_elem(rand_q30(), rand_q30());
        end
    endtask

    task automatic push_near_identity_link();
        logic signed [DATA_W-1:0] nre, nim;
        for (int k = 0; k < NSQ; k++) begin
            nre = $urandom;
            nim = $urandom;
            if (k % (MATRIX_DIM + 1) == 0) begin
                push_elem(Q_ONE + (nre >>> 12), nim >>> 12);
            end else begin
                push_elem(nre >>> 14, nim >>> 14);
            end
        end
    endtask

    task automatic wait_drain();
        do begin
            @(negedge i_clk);
        end while (n_accepted != n_queued || expected_prods.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input int unsigned v);
        wait_drain();
        @(posedge i_clk);
        i_cfg_valid        <= 1'b1;
        i_cfg_chain_length <= v[CHAIN_W-1:0];
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        chain_len = v[CHAIN_W-1:0];
    endtask

    initial begin : stimulus
        int unsigned len;
        int unsigned n_links;
        int          rand_start;
        for (int i = 0; i < NSQ; i++) begin
            acc_re[i]  = '0;
            acc_im[i]  = '0;
            part_re[i] = '0;
            part_im[i] = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // pass-through of the field extremes
        cfg_write(1);
        push_elem(Q_MAX, Q_MAX);
        push_elem(Q_MIN, Q_MIN);
        push_elem(32'sd0, 32'sd0);
        push_elem(32'sd1, -32'sd1);
        push_elem(-32'sd1, 32'sd1);
        push_elem(Q_MAX, Q_MIN);
        push_elem(Q_MIN, Q_MAX);
        push_elem(Q_ONE, 32'sd0);
        push_elem(32'sd0, -Q_ONE);

        // two-link chain driven into saturation
        cfg_write(2);
        for (int k = 0; k < NSQ; k++) begin
            push_elem((k % 2) ? Q_MAX : Q_MIN, (k % 3 == 0) ? Q_MIN : Q_MAX);
        end
        for (int k = 0; k < NSQ; k++) begin
            push_elem((k % 2) ? Q_MAX : Q_MIN, Q_MIN);
        end

        // zero length acts as one
        cfg_write(0);
        push_rand_link();

        // length lowered in the middle of a chain
        cfg_write(3);
        push_rand_link();
        push_rand_link();
        cfg_write(2);
        push_rand_link();
        cfg_write(4);
        push_rand_link();
        cfg_write(1);
        push_rand_link();

        rand_start = n_queued;
        while (n_queued < rand_start + RAND_ITEMS) begin
            if (n_queued - rand_start < RAND_ITEMS / 3) begin
                tx_idle_pct = 10;
                rx_idle_pct = 83;
            end else if (n_queued - rand_start < 2 * RAND_ITEMS / 3) begin
                tx_idle_pct = 83;
                rx_idle_pct = 10;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case ($urandom_range(9))
                0, 1, 2, 3, 4: len = $urandom_range(1, 2);
                5, 6, 7:       len = $urandom_range(3, 4);
                default:       len = $urandom_range(5, 8);
            endcase
            cfg_write(len);
            if ($urandom_range(3) != 0) begin
                n_links = len * $urandom_range(1, 3);
            end else begin
                n_links = $urandom_range(1, 2 * len);
            end
            repeat (n_links) push_rand_link();
        end

        // largest length, then lowered to close the chain
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        cfg_write(1023);
        repeat (5) push_near_identity_link();
        cfg_write(6);
        push_near_identity_link();

        wait_drain();
        if (fail_count == 0 && expected_prods.size() == 0) begin
            $display("** complex_matrix_chain_product_core: PASSED **");
        end else begin
            $display("** complex_matrix_chain_product_core: FAILED **");
        end
        $finish;
    end

    initial begin : watchdog
        #5000000;
        $display("** complex_matrix_chain_product_core: FAILED **");
        $finish;
    end

endmodule
